// ===== hdl/grg_pkg.sv =====
// shared types, command codes and fixed-point constants for the gamma ramp block
`timescale 1ns / 1ps

package grg_pkg;

  typedef logic [17:0] gamma_t;
  typedef logic [15:0] ramp_t;
  typedef logic [2:0]  cmd_t;

  // command codes
  localparam cmd_t CMD_SET    = 3'd0;
  localparam cmd_t CMD_INC    = 3'd1;
  localparam cmd_t CMD_DEC    = 3'd2;
  localparam cmd_t CMD_RESET  = 3'd3;
  localparam cmd_t CMD_LOOKUP = 3'd4;

  // gamma limits, 16 fraction bits
  localparam gamma_t GAMMA_ONE = 18'd65536;
  localparam gamma_t GAMMA_MAX = 18'd131072;

  // ramp full scale
  localparam ramp_t RAMP_MAX = 16'd65535;

  // ln(2) and 1.0 in Q30
  localparam logic [31:0] LN2_Q30 = 32'd744261118;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  // floor(2^31 / k) for k = 1..16, indexed by k-1
  localparam logic [31:0] RECIP_Q31 [16] = '{
    32'd2147483648, 32'd1073741824, 32'd715827882, 32'd536870912,
    32'd429496729,  32'd357913941,  32'd306783378, 32'd268435456,
    32'd238609294,  32'd214748364,  32'd195225786, 32'd178956970,
    32'd165191049,  32'd153391689,  32'd143165576, 32'd134217728
  };

endpackage

// ===== hdl/grg_pow.sv =====
// power-law ramp entry unit: log2 by squaring, exp2 by series, one shared multiplier
`timescale 1ns / 1ps

module grg_pow #(
  parameter int INDEX_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [7:0]      index,
  input  grg_pkg::gamma_t gamma,
  output logic            done,
  output grg_pkg::ramp_t  ramp
);
  import grg_pkg::*;

  localparam int          IDX_KEEP = (INDEX_BITS < 8) ? INDEX_BITS : 8;
  localparam logic [7:0]  IDX_MASK = 8'((1 << IDX_KEEP) - 1);
  localparam logic [27:0] D_TOP    = 28'(INDEX_BITS) << 24;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOG  = 4'd1;
  localparam logic [3:0] ST_DIFF = 4'd2;
  localparam logic [3:0] ST_TRND = 4'd3;
  localparam logic [3:0] ST_YMUL = 4'd4;
  localparam logic [3:0] ST_YSET = 4'd5;
  localparam logic [3:0] ST_SMUL = 4'd6;
  localparam logic [3:0] ST_SREC = 4'd7;
  localparam logic [3:0] ST_SCOR = 4'd8;
  localparam logic [3:0] ST_SUPD = 4'd9;
  localparam logic [3:0] ST_FMUL = 4'd10;
  localparam logic [3:0] ST_RND  = 4'd11;

  logic [3:0]  st_r, st_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [8:0]  v_r, v_nxt;
  gamma_t      g_r, g_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [23:0] frac_r, frac_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [29:0] t_r, t_nxt;
  logic [29:0] y_r, y_nxt;
  logic [30:0] term_r, term_nxt;
  logic [32:0] sum_r, sum_nxt;
  logic [29:0] p_r, p_nxt;
  logic [29:0] q0_r, q0_nxt;
  logic [3:0]  kidx_r, kidx_nxt;
  ramp_t       ramp_r, ramp_nxt;
  logic        done_r, done_nxt;

  logic [31:0] mul_a, mul_b;
  logic [8:0]  v_in;
  logic [3:0]  k_in;
  logic [30:0] m0, m_next;
  logic        sq_bit;
  logic [27:0] d_val;
  logic [4:0]  kval;
  logic [29:0] rem, q;
  logic [30:0] s_val;
  logic [5:0]  n_val;
  logic [46:0] sh, half;

  // shared multiplier, product always registered
  assign prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    v_in = {1'b0, index & IDX_MASK} + 9'd1;
    k_in = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (v_in[i]) k_in = 4'(i);
    end
  end

  assign m0     = {22'd0, v_r} << (5'd30 - {1'b0, k_r});
  assign sq_bit = prod_r[61];
  assign m_next = sq_bit ? prod_r[61:31] : prod_r[60:30];
  assign d_val  = D_TOP - {k_r, frac_r};
  assign kval   = {1'b0, kidx_r} + 5'd1;
  assign rem    = p_r - prod_r[29:0];
  assign q      = (rem >= 30'(kval)) ? q0_r + 30'd1 : q0_r;
  assign s_val  = sum_r[32] ? 31'd0 : sum_r[30:0];
  assign n_val  = t_r[29:24];
  assign sh     = prod_r[46:0] >> (7'd29 + 7'(n_val));
  assign half   = (sh + 47'd1) >> 1;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    g_nxt    = g_r;
    k_nxt    = k_r;
    frac_nxt = frac_r;
    t_nxt    = t_r;
    y_nxt    = y_r;
    term_nxt = term_r;
    sum_nxt  = sum_r;
    p_nxt    = p_r;
    q0_nxt   = q0_r;
    kidx_nxt = kidx_r;
    ramp_nxt = ramp_r;
    done_nxt = 1'b0;
    mul_a    = 32'd0;
    mul_b    = 32'd0;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          v_nxt   = v_in;
          g_nxt   = gamma;
          k_nxt   = k_in;
          cnt_nxt = 5'd0;
          st_nxt  = ST_LOG;
        end
      end
      ST_LOG: begin
        // one squaring per cycle, one fraction bit per square
        if (cnt_r == 5'd0) begin
          mul_a = 32'(m0);
          mul_b = 32'(m0);
        end else begin
          frac_nxt = {frac_r[22:0], sq_bit};
          mul_a    = 32'(m_next);
          mul_b    = 32'(m_next);
        end
        if (cnt_r == 5'd24) begin
          st_nxt = ST_DIFF;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_DIFF: begin
        mul_a  = 32'(g_r);
        mul_b  = 32'(d_val);
        st_nxt = ST_TRND;
      end
      ST_TRND: begin
        t_nxt  = 30'((prod_r[45:0] + 46'd32768) >> 16);
        st_nxt = ST_YMUL;
      end
      ST_YMUL: begin
        mul_a  = 32'(t_r[23:0]);
        mul_b  = LN2_Q30;
        st_nxt = ST_YSET;
      end
      ST_YSET: begin
        y_nxt    = prod_r[53:24];
        term_nxt = Q30_ONE;
        sum_nxt  = 33'(Q30_ONE);
        kidx_nxt = 4'd0;
        st_nxt   = ST_SMUL;
      end
      ST_SMUL: begin
        mul_a  = 32'(term_r);
        mul_b  = 32'(y_r);
        st_nxt = ST_SREC;
      end
      ST_SREC: begin
        // divide by k via reciprocal, corrected next
        p_nxt  = prod_r[59:30];
        mul_a  = 32'(prod_r[59:30]);
        mul_b  = RECIP_Q31[kidx_r];
        st_nxt = ST_SCOR;
      end
      ST_SCOR: begin
        q0_nxt = prod_r[60:31];
        mul_a  = 32'(prod_r[60:31]);
        mul_b  = 32'(kval);
        st_nxt = ST_SUPD;
      end
      ST_SUPD: begin
        term_nxt = 31'(q);
        sum_nxt  = kidx_r[0] ? sum_r + 33'(q) : sum_r - 33'(q);
        if (kidx_r == 4'd15) begin
          st_nxt = ST_FMUL;
        end else begin
          kidx_nxt = kidx_r + 4'd1;
          st_nxt   = ST_SMUL;
        end
      end
      ST_FMUL: begin
        mul_a  = 32'(s_val);
        mul_b  = 32'(RAMP_MAX);
        st_nxt = ST_RND;
      end
      ST_RND: begin
        if (n_val > 6'd30) begin
          ramp_nxt = 16'd0;
        end else if (half > 47'(RAMP_MAX)) begin
          ramp_nxt = RAMP_MAX;
        end else begin
          ramp_nxt = half[15:0];
        end
        done_nxt = 1'b1;
        st_nxt   = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    v_r    <= v_nxt;
    g_r    <= g_nxt;
    k_r    <= k_nxt;
    frac_r <= frac_nxt;
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    y_r    <= y_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    p_r    <= p_nxt;
    q0_r   <= q0_nxt;
    kidx_r <= kidx_nxt;
    ramp_r <= ramp_nxt;
  end

  assign done = done_r;
  assign ramp = ramp_r;

endmodule

// ===== hdl/gamma_ramp_generator.sv =====
// top level: gamma register, command handling and ramp lookup sequencing
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------------
//   in      | request   | in_valid, in_ready, in_command, in_amount, in_index
//   out     | result    | out_valid, out_ready, out_ramp_value, out_gamma_now,
//           |           | out_rejected
//
// set, increase, decrease, reset and unknown commands finish in the accept cycle;
//   the result shows in the output register on the next cycle
// a lookup runs in the power unit: 25 squaring steps for log2 and
//   16 series terms of four steps each for exp2, all through its one shared multiplier
// no new request is taken while a lookup runs; a request is taken while a result
//   waits, as long as that result is drained in the same cycle
// rst_n is synchronous, active low; gamma returns to 1.0
`timescale 1ns / 1ps

module gamma_ramp_generator #(
  parameter int INDEX_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  grg_pkg::cmd_t   in_command,
  input  logic [17:0]     in_amount,
  input  logic [7:0]      in_index,
  output logic            out_valid,
  input  logic            out_ready,
  output grg_pkg::ramp_t  out_ramp_value,
  output grg_pkg::gamma_t out_gamma_now,
  output logic            out_rejected
);
  import grg_pkg::*;

  // sequencer states
  localparam logic ST_FREE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic   state_r, state_nxt;
  gamma_t gamma_r, gamma_nxt;
  logic   out_valid_r, out_valid_nxt;
  ramp_t  out_ramp_r, out_ramp_nxt;
  gamma_t out_gamma_r, out_gamma_nxt;
  logic   out_rej_r, out_rej_nxt;

  logic        accept;
  logic        is_lookup;
  logic        too_big;
  logic        rej;
  logic [18:0] inc_sum;
  gamma_t      cmd_gamma;
  logic        pow_start;
  logic        pow_done;
  ramp_t       pow_ramp;

  // take a request when idle and the output register is free or draining
  assign in_ready  = (state_r == ST_FREE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign is_lookup = (in_command == CMD_LOOKUP);
  assign too_big   = (in_amount > GAMMA_MAX);
  assign inc_sum   = {1'b0, gamma_r} + {1'b0, in_amount};
  assign pow_start = accept && is_lookup;

  // gamma update for the command at the input
  always_comb begin
    cmd_gamma = gamma_r;
    rej       = (in_command inside {CMD_SET, CMD_INC, CMD_DEC}) && too_big;
    case (in_command)
      CMD_SET: begin
        if (!too_big) cmd_gamma = in_amount;
      end
      CMD_INC: begin
        if (!too_big) begin
          // saturate at 2.0
          cmd_gamma = (inc_sum > 19'(GAMMA_MAX)) ? GAMMA_MAX : inc_sum[17:0];
        end
      end
      CMD_DEC: begin
        if (!too_big) begin
          // floor at zero
          cmd_gamma = (in_amount > gamma_r) ? 18'd0 : gamma_r - in_amount;
        end
      end
      CMD_RESET: begin
        cmd_gamma = GAMMA_ONE;
      end
      default: begin
        cmd_gamma = gamma_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    gamma_nxt     = gamma_r;
    out_valid_nxt = out_valid_r;
    out_ramp_nxt  = out_ramp_r;
    out_gamma_nxt = out_gamma_r;
    out_rej_nxt   = out_rej_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (accept) begin
      gamma_nxt = cmd_gamma;
      if (is_lookup) begin
        state_nxt = ST_BUSY;
      end else begin
        // non-lookup result goes straight to the output register
        out_valid_nxt = 1'b1;
        out_ramp_nxt  = 16'd0;
        out_gamma_nxt = cmd_gamma;
        out_rej_nxt   = rej;
      end
    end

    if (state_r == ST_BUSY && pow_done) begin
      state_nxt     = ST_FREE;
      out_valid_nxt = 1'b1;
      out_ramp_nxt  = pow_ramp;
      out_gamma_nxt = gamma_r;
      out_rej_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FREE;
      gamma_r     <= GAMMA_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gamma_r     <= gamma_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ramp_r  <= out_ramp_nxt;
    out_gamma_r <= out_gamma_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  // ramp entry unit
  grg_pow #(
    .INDEX_BITS(INDEX_BITS)
  ) u_pow (
    .clk  (clk),
    .rst_n(rst_n),
    .start(pow_start),
    .index(in_index),
    .gamma(gamma_r),
    .done (pow_done),
    .ramp (pow_ramp)
  );

  assign out_valid      = out_valid_r;
  assign out_ramp_value = out_ramp_r;
  assign out_gamma_now  = out_gamma_r;
  assign out_rejected   = out_rej_r;

`ifndef NO_ASSERTIONS
  // gamma never leaves 0..2.0
  a_gamma_range: assert property (@(posedge clk) disable iff (!rst_n)
    gamma_r <= GAMMA_MAX)
    else $error("gamma above 2.0");

  // a lookup result lands only in an empty output register
  a_done_room: assert property (@(posedge clk) disable iff (!rst_n)
    pow_done |-> (state_r == ST_BUSY) && !out_valid_r)
    else $error("lookup finished with no room or while not busy");

  // gamma holds while a lookup runs
  a_gamma_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |=> $stable(gamma_r))
    else $error("gamma changed during lookup");
`endif

endmodule
